>>> sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the share statistics tracker
// Event codes, sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int TopCount     = 10;
	localparam int LatDepth     = 256;
	localparam int LatAw        = $clog2(LatDepth);
	localparam int LatCw        = $clog2(LatDepth + 1);
	localparam int TopRw        = 4;
	localparam logic [15:0] LatSat = 16'hFFFF;

	typedef enum logic [2:0] {
		MODE_ACCEPT = 3'd0,
		MODE_REJECT = 3'd1,
		MODE_START  = 3'd2,
		MODE_JOB    = 3'd3,
		MODE_STOP   = 3'd4,
		MODE_READ   = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS,
		ST_MED_I,
		ST_MED_RD,
		ST_MED_CHK,
		ST_MED_CMP,
		ST_MED_DONE,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

>>> sv/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> sv/share_statistics_tracker_core.sv
// ----------------------------------------------------------------------------
// share_statistics_tracker_core: submission statistics for one connection
// Counts shares, keeps a top list of difficulties and a latency store,
// reports median latency and average time per stored latency.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  command   start / busy     mode, share_diff, actual_diff, elapsed_ms, job_diff, now_ms
//  result    strobe           status fields, top_rank, top_diff, last
//
//  Median: selection by counting over the latency store, one RAM read a cycle;
//  each candidate is read once and then compared with every stored latency,
//  and an empty store skips the scan. Top list insert one rank per cycle
//  (accepted shares only) comes before the median. After the median come
//  set-up and restoring division, one quotient bit a cycle, then one result,
//  or one per top-list rank for a read. Reset clears all control state; the
//  latency RAM needs no clearing. The receiver cannot stall: results go out
//  one per cycle, busy stays high.
// ----------------------------------------------------------------------------
module share_statistics_tracker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [63:0] share_diff,
	input  logic [63:0] actual_diff,
	input  logic [31:0] elapsed_ms,
	input  logic [63:0] job_diff,
	input  logic [47:0] now_ms,
	output logic        strobe,
	output logic [63:0] accepted_count,
	output logic [63:0] rejected_count,
	output logic [63:0] credit_sum,
	output logic [63:0] current_diff,
	output logic [15:0] median_latency_ms,
	output logic [47:0] avg_span_ms,
	output logic [31:0] failure_count,
	output logic [3:0]  top_rank,
	output logic [63:0] top_diff,
	output logic        connection_up,
	output logic        last
);
	import sst_pkg::*;

	state_t state_q, state_d;

	logic [63:0] acc_q, rej_q, hsum_q, job_q;
	logic        act_q;
	logic [47:0] cstart_q;
	logic [31:0] fail_q;
	logic [63:0] best_q [TopCount];
	logic [LatCw-1:0] cnt_q;

	logic [2:0]  mode_q;
	logic [63:0] adiff_q;
	logic [47:0] now_q;
	logic [TopRw-1:0] k_q;      // insert position / output rank
	logic [LatCw-1:0] i_q, j_q; // median candidate / scan index
	logic [15:0] cand_q;
	logic [LatCw-1:0] less_q, leq_q;
	logic [15:0] med_q;
	logic [47:0] span_q, quo_q;
	logic [LatCw-1:0] rem_q;
	logic [5:0]  bit_q;

	logic             we;
	logic [LatAw-1:0] waddr, raddr;
	logic [15:0]      wdata, rdata;

	sst_ram #(.Width(16), .Depth(LatDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic accept;
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign we    = accept && (mode == MODE_ACCEPT) && (cnt_q < LatCw'(LatDepth));
	assign waddr = cnt_q[LatAw-1:0];
	assign wdata = (elapsed_ms > {16'd0, LatSat}) ? LatSat : elapsed_ms[15:0];
	assign raddr = (state_q == ST_MED_I) ? i_q[LatAw-1:0] : j_q[LatAw-1:0];

	logic [LatCw:0] rem_sh;
	assign rem_sh = {rem_q, span_q[47]};

	// median target index: cnt/2; candidate is the answer when
	// less < target+1 <= leq
	logic [LatCw-1:0] tgt;
	assign tgt = cnt_q >> 1;

	logic med_hit;
	assign med_hit = (less_q <= tgt) && (tgt < leq_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) begin
				if (mode == MODE_ACCEPT) state_d = ST_INS;
				else state_d = ST_MED_I;
			end
			ST_INS: if (k_q == 0 || best_q[k_q - 1'b1] >= adiff_q) state_d = ST_MED_I;
			ST_MED_I: begin
				if (cnt_q == '0) state_d = ST_MED_DONE;
				else state_d = ST_MED_RD;
			end
			ST_MED_RD: state_d = ST_MED_CMP;
			ST_MED_CMP: if (j_q == cnt_q) state_d = ST_MED_CHK;
			ST_MED_CHK: begin
				if (med_hit || i_q == cnt_q - 1'b1) state_d = ST_MED_DONE;
				else state_d = ST_MED_I;
			end
			ST_MED_DONE: state_d = ST_DIV;
			ST_DIV: if (bit_q == 6'd0) state_d = ST_OUT;
			ST_OUT: if (mode_q != MODE_READ || k_q == TopRw'(TopCount - 1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; rej_q <= '0; hsum_q <= '0; job_q <= '0;
			act_q <= 1'b0; cstart_q <= '0; fail_q <= '0; cnt_q <= '0;
			for (int t = 0; t < TopCount; t++) best_q[t] <= '0;
			mode_q <= '0; k_q <= '0; i_q <= '0; j_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					mode_q <= mode;
					k_q    <= TopRw'(TopCount - 1);
					unique case (mode)
						MODE_ACCEPT: begin
							acc_q  <= acc_q + 64'd1;
							hsum_q <= hsum_q + share_diff;
							if (cnt_q < LatCw'(LatDepth)) cnt_q <= cnt_q + 1'b1;
						end
						MODE_REJECT: rej_q <= rej_q + 64'd1;
						MODE_START: begin
							act_q <= 1'b1; cstart_q <= now_ms;
						end
						MODE_JOB: job_q <= job_diff;
						MODE_STOP: begin
							act_q <= 1'b0; job_q <= '0; cnt_q <= '0;
							if (fail_q != '1) fail_q <= fail_q + 32'd1;
						end
						default: ;
					endcase
				end
				ST_INS: begin
					if (k_q == TopRw'(TopCount - 1) && adiff_q <= best_q[k_q]) begin
						k_q <= '0; // leave list unchanged
					end else if (k_q != 0 && best_q[k_q - 1'b1] < adiff_q) begin
						best_q[k_q] <= best_q[k_q - 1'b1];
						k_q <= k_q - 1'b1;
					end else begin
						best_q[k_q] <= adiff_q;
						k_q <= '0;
					end
				end
				ST_MED_I: j_q <= '0;
				ST_MED_RD: j_q <= j_q + 1'b1;
				ST_MED_CMP: if (j_q != cnt_q) j_q <= j_q + 1'b1;
				ST_MED_CHK: i_q <= i_q + 1'b1;
				ST_MED_DONE: k_q <= '0;
				ST_OUT: k_q <= k_q + 1'b1;
				default: ;
			endcase
			if (state_q == ST_IDLE) i_q <= '0;
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			adiff_q <= actual_diff;
			now_q   <= now_ms;
			med_q   <= '0;
		end
		unique case (state_q)
			ST_MED_RD: begin
				cand_q <= rdata; less_q <= '0; leq_q <= '0;
			end
			ST_MED_CMP: begin
				// j_q points one ahead of the word in rdata
				if (rdata < cand_q) less_q <= less_q + 1'b1;
				if (rdata <= cand_q) leq_q <= leq_q + 1'b1;
			end
			ST_MED_CHK: if (med_hit) med_q <= cand_q;
			ST_MED_DONE: begin
				span_q <= act_q ? (now_q - cstart_q) : '0;
				quo_q  <= '0;
				rem_q  <= '0;
				bit_q  <= 6'd48;
			end
			ST_DIV: if (bit_q != 0) begin
				bit_q  <= bit_q - 1'b1;
				span_q <= {span_q[46:0], 1'b0};
				if (rem_sh >= {1'b0, cnt_q}) begin
					rem_q <= LatCw'(rem_sh - {1'b0, cnt_q});
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= rem_sh[LatCw-1:0];
					quo_q <= {quo_q[46:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign strobe            = (state_q == ST_OUT);
	assign accepted_count    = acc_q;
	assign rejected_count    = rej_q;
	assign credit_sum        = hsum_q;
	assign current_diff      = job_q;
	assign median_latency_ms = (cnt_q == 0) ? 16'd0 : med_q;
	assign avg_span_ms       = (cnt_q == 0) ? 48'd0 : quo_q;
	assign failure_count     = fail_q;
	assign top_rank          = k_q;
	assign top_diff          = (k_q < TopRw'(TopCount)) ? best_q[k_q] : '0;
	assign connection_up     = act_q;
	assign last              = (mode_q != MODE_READ) || (k_q == TopRw'(TopCount - 1));

endmodule
